// ===== rtl/perlin_fbm_noise_2d_defines.svh =====
// Assertion macros shared by the noise block
`ifndef PERLIN_FBM_NOISE_2D_DEFINES_SVH
`define PERLIN_FBM_NOISE_2D_DEFINES_SVH

// Property checked at every clock edge outside reset
`define PFBM_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Consequent checked in the cycle after the antecedent
`define PFBM_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) \
    (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/pfbm_pkg.sv =====
// Shared constants and types of the fractal gradient noise block
package pfbm_pkg;

  localparam int unsigned TABLE_ENTRIES_C  = 256;
  localparam int unsigned TABLE_AW         = 8;
  localparam int unsigned PERM_W           = 8;
  localparam int unsigned MAX_OCTAVES_C    = 8;
  localparam int unsigned FRACTION_BITS_C  = 16;
  localparam int unsigned POINT_BITS       = 40;
  localparam int unsigned COORD_W          = 32;
  localparam int unsigned FREQ_W           = 24;
  localparam int unsigned AMP_W            = 16;
  localparam int unsigned COUNT_W          = 4;
  localparam int unsigned PROD_W           = COORD_W + FREQ_W;
  localparam int unsigned OUT_W            = 18;
  localparam int unsigned AMP_SHIFT        = 16;
  // register stages from the product register to the octave term
  localparam int unsigned OCT_LAT          = 9;

  typedef struct packed {
    logic                en;
    logic [TABLE_AW-1:0] addr;
    logic [PERM_W-1:0]   data;
  } perm_wr_t;

endpackage

// ===== rtl/pfbm_perm_ram.sv =====
// Permutation table copy: one write port, two registered read ports
module pfbm_perm_ram (
  input  logic                              clk_i,
  input  pfbm_pkg::perm_wr_t                wr_i,
  input  logic                              rd_en_i,
  input  logic [pfbm_pkg::TABLE_AW-1:0]     rd_addr0_i,
  input  logic [pfbm_pkg::TABLE_AW-1:0]     rd_addr1_i,
  output logic [pfbm_pkg::PERM_W-1:0]       rd_data0_o,
  output logic [pfbm_pkg::PERM_W-1:0]       rd_data1_o
);
  import pfbm_pkg::*;

  logic [PERM_W-1:0] mem [TABLE_ENTRIES_C];

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem[wr_i.addr] <= wr_i.data;
    end
    if (rd_en_i) begin
      rd_data0_o <= mem[rd_addr0_i];
      rd_data1_o <= mem[rd_addr1_i];
    end
  end

endmodule

// ===== rtl/pfbm_octave.sv =====
// One octave of gradient noise: cell hash, fade, bilinear blend and weight
module pfbm_octave #(
  parameter int unsigned FRACTION_BITS = pfbm_pkg::FRACTION_BITS_C,
  parameter int unsigned OCT_IDX       = 0
) (
  input  logic                                clk_i,
  input  logic                                en_i,
  input  pfbm_pkg::perm_wr_t                  wr_a_i,
  input  pfbm_pkg::perm_wr_t                  wr_b_i,
  input  logic signed [pfbm_pkg::PROD_W-1:0]  prod_x_i,
  input  logic signed [pfbm_pkg::PROD_W-1:0]  prod_y_i,
  input  logic [pfbm_pkg::COUNT_W-1:0]        octave_count_i,
  input  logic [pfbm_pkg::AMP_W-1:0]          base_amplitude_i,
  output logic signed [FRACTION_BITS+2:0]     term_o
);
  import pfbm_pkg::*;

  localparam int unsigned FB  = FRACTION_BITS;
  localparam int unsigned DW  = FB + 3;             // dot products and blends
  localparam int unsigned FW  = FB + 1;             // fade value, up to one
  localparam int unsigned IW  = FB + 5;             // fade inner polynomial
  localparam int unsigned NW  = FB + 4;             // inner, stored unsigned
  localparam int unsigned MW  = FW + 1 + DW + 1;    // blend products
  localparam int unsigned PW  = DW + AMP_W + 1;     // weighted noise
  localparam int unsigned TW  = FB + 3;
  localparam int unsigned CELL_HI = POINT_BITS + TABLE_AW - 1 - OCT_IDX;
  localparam int unsigned FRAC_HI = POINT_BITS - 1 - OCT_IDX;
  localparam logic signed [DW-1:0] ONE = DW'(1) << FB;

  typedef enum logic [1:0] {
    GRAD_PP = 2'd0,
    GRAD_NP = 2'd1,
    GRAD_NN = 2'd2,
    GRAD_PN = 2'd3
  } grad_e;

  function automatic logic signed [DW-1:0] corner_dot(input logic [1:0] h,
                                                      input logic signed [DW-1:0] a,
                                                      input logic signed [DW-1:0] b);
    logic signed [DW-1:0] r;
    case (grad_e'(h))
      GRAD_PP: r = a + b;
      GRAD_NP: r = b - a;
      GRAD_NN: r = -a - b;
      GRAD_PN: r = a - b;
      default: r = a + b;
    endcase
    return r;
  endfunction

  // stage 2 -> 3
  logic [TABLE_AW-1:0] cx_c, cy_c, cx1_c;
  logic [FB-1:0]       tx_c, ty_c;
  logic [2*FB-1:0]     sqx_c, sqy_c;
  logic [FB-1:0]       t2x_q, t2y_q, tx3_q, ty3_q;
  logic [TABLE_AW-1:0] cy3_q;
  logic [PERM_W-1:0]   pa_q, pb_q;

  assign cx_c  = prod_x_i[CELL_HI -: TABLE_AW];
  assign cy_c  = prod_y_i[CELL_HI -: TABLE_AW];
  assign cx1_c = cx_c + TABLE_AW'(1);
  assign tx_c  = prod_x_i[FRAC_HI -: FB];
  assign ty_c  = prod_y_i[FRAC_HI -: FB];
  assign sqx_c = tx_c * tx_c;
  assign sqy_c = ty_c * ty_c;

  pfbm_perm_ram u_ram_a (
    .clk_i      (clk_i),
    .wr_i       (wr_a_i),
    .rd_en_i    (en_i),
    .rd_addr0_i (cx_c),
    .rd_addr1_i (cx1_c),
    .rd_data0_o (pa_q),
    .rd_data1_o (pb_q)
  );

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      t2x_q <= sqx_c[2*FB-1:FB];
      t2y_q <= sqy_c[2*FB-1:FB];
      tx3_q <= tx_c;
      ty3_q <= ty_c;
      cy3_q <= cy_c;
    end
  end

  // stage 3 -> 4
  logic [TABLE_AW-1:0] cy1_c, a_bl_c, a_tl_c, a_br_c, a_tr_c;
  logic [2*FB-1:0]     cbx_c, cby_c;
  logic [IW-1:0]       inx_c, iny_c;
  logic [FB-1:0]       t3x_q, t3y_q, tx4_q, ty4_q;
  logic [NW-1:0]       inx_q, iny_q;
  logic [PERM_W-1:0]   hbl_q, htl_q, hbr_q, htr_q;

  assign cy1_c  = cy3_q + TABLE_AW'(1);
  assign a_bl_c = pa_q + cy3_q;
  assign a_tl_c = pa_q + cy1_c;
  assign a_br_c = pb_q + cy3_q;
  assign a_tr_c = pb_q + cy1_c;
  assign cbx_c  = t2x_q * tx3_q;
  assign cby_c  = t2y_q * ty3_q;
  assign inx_c  = IW'(t2x_q) * IW'(6) + (IW'(10) << FB) - IW'(tx3_q) * IW'(15);
  assign iny_c  = IW'(t2y_q) * IW'(6) + (IW'(10) << FB) - IW'(ty3_q) * IW'(15);

  pfbm_perm_ram u_ram_b0 (
    .clk_i      (clk_i),
    .wr_i       (wr_b_i),
    .rd_en_i    (en_i),
    .rd_addr0_i (a_bl_c),
    .rd_addr1_i (a_tl_c),
    .rd_data0_o (hbl_q),
    .rd_data1_o (htl_q)
  );

  pfbm_perm_ram u_ram_b1 (
    .clk_i      (clk_i),
    .wr_i       (wr_b_i),
    .rd_en_i    (en_i),
    .rd_addr0_i (a_br_c),
    .rd_addr1_i (a_tr_c),
    .rd_data0_o (hbr_q),
    .rd_data1_o (htr_q)
  );

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      t3x_q <= cbx_c[2*FB-1:FB];
      t3y_q <= cby_c[2*FB-1:FB];
      inx_q <= inx_c[NW-1:0];
      iny_q <= iny_c[NW-1:0];
      tx4_q <= tx3_q;
      ty4_q <= ty3_q;
    end
  end

  // stage 4 -> 5
  logic [2*FB+3:0]       fx_c, fy_c;
  logic signed [DW-1:0]  dx_c, dy_c, dx1_c, dy1_c;
  logic [FW-1:0]         u5_q, v5_q;
  logic signed [DW-1:0]  bl5_q, tl5_q, br5_q, tr5_q;

  assign fx_c  = t3x_q * inx_q;
  assign fy_c  = t3y_q * iny_q;
  assign dx_c  = $signed(DW'(tx4_q));
  assign dy_c  = $signed(DW'(ty4_q));
  assign dx1_c = dx_c - ONE;
  assign dy1_c = dy_c - ONE;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      u5_q  <= fx_c[FB+FW-1:FB];
      v5_q  <= fy_c[FB+FW-1:FB];
      bl5_q <= corner_dot(hbl_q[1:0], dx_c, dy_c);
      tl5_q <= corner_dot(htl_q[1:0], dx_c, dy1_c);
      br5_q <= corner_dot(hbr_q[1:0], dx1_c, dy_c);
      tr5_q <= corner_dot(htr_q[1:0], dx1_c, dy1_c);
    end
  end

  // stage 5 -> 6: blend along y
  logic signed [DW:0]    dl_c, dr_c;
  logic signed [MW-1:0]  m1_c, m2_c, m1_q, m2_q;
  logic signed [DW-1:0]  bl6_q, br6_q;
  logic [FW-1:0]         u6_q;

  assign dl_c = {tl5_q[DW-1], tl5_q} - {bl5_q[DW-1], bl5_q};
  assign dr_c = {tr5_q[DW-1], tr5_q} - {br5_q[DW-1], br5_q};
  assign m1_c = $signed({1'b0, v5_q}) * dl_c;
  assign m2_c = $signed({1'b0, v5_q}) * dr_c;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      m1_q  <= m1_c;
      m2_q  <= m2_c;
      bl6_q <= bl5_q;
      br6_q <= br5_q;
      u6_q  <= u5_q;
    end
  end

  // stage 6 -> 7
  logic signed [MW-1:0] m1s_c, m2s_c;
  logic signed [DW-1:0] l1_q, l2_q;
  logic [FW-1:0]        u7_q;

  assign m1s_c = m1_q >>> FB;
  assign m2s_c = m2_q >>> FB;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      l1_q <= bl6_q + m1s_c[DW-1:0];
      l2_q <= br6_q + m2s_c[DW-1:0];
      u7_q <= u6_q;
    end
  end

  // stage 7 -> 8: blend along x
  logic signed [DW:0]   dx_l_c;
  logic signed [MW-1:0] m3_c, m3_q;
  logic signed [DW-1:0] l1_8_q;

  assign dx_l_c = {l2_q[DW-1], l2_q} - {l1_q[DW-1], l1_q};
  assign m3_c   = $signed({1'b0, u7_q}) * dx_l_c;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      m3_q   <= m3_c;
      l1_8_q <= l1_q;
    end
  end

  // stage 8 -> 9
  logic signed [MW-1:0] m3s_c;
  logic signed [DW-1:0] n_q;

  assign m3s_c = m3_q >>> FB;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      n_q <= l1_8_q + m3s_c[DW-1:0];
    end
  end

  // stage 9 -> 10: weight
  logic signed [PW-1:0] w_c, w_q;

  assign w_c = n_q * $signed({1'b0, base_amplitude_i});

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      w_q <= w_c;
    end
  end

  // stage 10 -> 11: scale by the octave's amplitude and drop unused octaves
  logic signed [PW-1:0] ws_c;
  logic                 active_c;

  assign ws_c     = w_q >>> (AMP_SHIFT + OCT_IDX);
  assign active_c = COUNT_W'(OCT_IDX) < octave_count_i;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      term_o <= active_c ? ws_c[TW-1:0] : '0;
    end
  end

endmodule

// ===== rtl/pfbm_sum.sv =====
// Registered adder tree over the octave terms
module pfbm_sum #(
  parameter int unsigned N  = pfbm_pkg::MAX_OCTAVES_C,
  parameter int unsigned IW = pfbm_pkg::FRACTION_BITS_C + 3,
  parameter int unsigned OW = pfbm_pkg::FRACTION_BITS_C + 8
) (
  input  logic                 clk_i,
  input  logic                 en_i,
  input  logic signed [IW-1:0] terms_i [N],
  output logic signed [OW-1:0] sum_o
);
  import pfbm_pkg::*;

  localparam int unsigned L  = (N > 1) ? $clog2(N) : 0;
  localparam int unsigned P  = 1 << L;
  localparam int unsigned LQ = (L > 0) ? L : 1;

  logic signed [OW-1:0] leaf [P];
  logic signed [OW-1:0] node_q [LQ][P];

  always_comb begin
    for (int j = 0; j < P; j++) begin
      leaf[j] = (j < N) ? OW'(terms_i[j]) : '0;
    end
  end

  for (genvar lv = 1; lv <= L; lv++) begin : g_level
    if (lv == 1) begin : g_first
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          for (int j = 0; j < P; j++) begin
            if (j < (P >> 1)) begin
              node_q[0][j] <= leaf[2*j] + leaf[2*j+1];
            end else begin
              node_q[0][j] <= '0;
            end
          end
        end
      end
    end else begin : g_next
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          for (int j = 0; j < P; j++) begin
            if (j < (P >> lv)) begin
              node_q[lv-1][j] <= node_q[lv-2][2*j] + node_q[lv-2][2*j+1];
            end else begin
              node_q[lv-1][j] <= '0;
            end
          end
        end
      end
    end
  end

  if (L > 0) begin : g_tree
    assign sum_o = node_q[L-1][0];
  end else begin : g_pass
    assign sum_o = leaf[0];
  end

endmodule

// ===== rtl/perlin_fbm_noise_2d.sv =====
// Top level of the fractal Brownian motion gradient noise block
//
// Input stream s_axis: tuser selects the command. A write beat (tuser 0)
// stores tdata[15:8] into permutation entry tdata[7:0] and yields no result.
// An evaluate beat (tuser 1) carries signed Q16.16 x in tdata[47:16] and y
// in tdata[79:48] and yields one beat on m_axis: signed Q2.16 noise in
// tdata[17:0], the sum of up to eight octaves, saturated.
// Configuration: cfg_index_i 0 is the octave count, 1 the base frequency
// (Q0.24), 2 the base amplitude (Q0.16); other indexes are dropped. Write
// it only while no beat is in flight.
// One beat enters per cycle unless the receiver stalls or the table load runs. A
// result passes 11 pipeline stages, log2 of MAX_OCTAVES levels of the
// adder tree and one output register; every octave has its own datapath and
// three copies of the permutation table, so throughput is one beat a cycle while nothing stalls.
// After reset the table is loaded with the identity by a pass over all 256
// entries during which s_axis_tready stays low. When the receiver stalls, the output
// register holds and the whole pipeline freezes; no beat is lost.
`include "perlin_fbm_noise_2d_defines.svh"

module perlin_fbm_noise_2d #(
  parameter int unsigned MAX_OCTAVES   = pfbm_pkg::MAX_OCTAVES_C,
  parameter int unsigned FRACTION_BITS = pfbm_pkg::FRACTION_BITS_C
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // table_index[7:0], table_value[15:8], x_coord[47:16], y_coord[79:48]
  input  logic [79:0] s_axis_tdata,
  // command[0]
  input  logic        s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // noise_value[17:0], zeros above
  output logic [23:0] m_axis_tdata,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [23:0] cfg_data_i
);
  import pfbm_pkg::*;

  typedef enum logic [1:0] {
    REG_OCTAVE_COUNT   = 2'd0,
    REG_BASE_FREQUENCY = 2'd1,
    REG_BASE_AMPLITUDE = 2'd2
  } cfg_reg_e;

  typedef enum logic {
    CMD_WRITE    = 1'b0,
    CMD_EVALUATE = 1'b1
  } cmd_e;

  typedef struct packed {
    logic valid;
    logic eval;
  } ctrl_t;

  localparam int unsigned L          = (MAX_OCTAVES > 1) ? $clog2(MAX_OCTAVES) : 0;
  localparam int unsigned CTRL_DEPTH = 2 + OCT_LAT + L;
  localparam int unsigned TW         = FRACTION_BITS + 3;
  localparam int unsigned SW         = FRACTION_BITS + 8;
  localparam int unsigned QW         = SW + 16;
  localparam logic signed [QW-1:0] OUT_MAX = QW'((1 << (OUT_W - 1)) - 1);
  localparam logic signed [QW-1:0] OUT_MIN = -QW'(1 << (OUT_W - 1));

  // configuration registers
  logic [COUNT_W-1:0] octave_count_q;
  logic [FREQ_W-1:0]  base_frequency_q;
  logic [AMP_W-1:0]   base_amplitude_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      octave_count_q   <= COUNT_W'(4);
      base_frequency_q <= FREQ_W'(83886);
      base_amplitude_q <= AMP_W'(58982);
    end else if (cfg_valid_i) begin
      case (cfg_reg_e'(cfg_index_i))
        REG_OCTAVE_COUNT:   octave_count_q   <= cfg_data_i[COUNT_W-1:0];
        REG_BASE_FREQUENCY: base_frequency_q <= cfg_data_i[FREQ_W-1:0];
        REG_BASE_AMPLITUDE: base_amplitude_q <= cfg_data_i[AMP_W-1:0];
        default: ;
      endcase
    end
  end

  // identity load of the table after reset
  logic                clearing_q;
  logic [TABLE_AW-1:0] clr_cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clearing_q <= 1'b1;
      clr_cnt_q  <= '0;
    end else if (clearing_q) begin
      clr_cnt_q <= clr_cnt_q + TABLE_AW'(1);
      if (clr_cnt_q == TABLE_AW'(TABLE_ENTRIES_C - 1)) begin
        clearing_q <= 1'b0;
      end
    end
  end

  // pipeline control
  logic  en;
  logic  in_acc;
  ctrl_t ctrl_q [CTRL_DEPTH];
  logic  out_vld_q;
  logic [OUT_W-1:0] noise_q;

  assign en            = !out_vld_q || m_axis_tready;
  assign s_axis_tready = en && !clearing_q;
  assign in_acc        = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < CTRL_DEPTH; k++) begin
        ctrl_q[k] <= '0;
      end
      out_vld_q <= 1'b0;
    end else if (en) begin
      ctrl_q[0] <= '{valid: in_acc, eval: cmd_e'(s_axis_tuser) == CMD_EVALUATE};
      for (int k = 1; k < CTRL_DEPTH; k++) begin
        ctrl_q[k] <= ctrl_q[k-1];
      end
      out_vld_q <= ctrl_q[CTRL_DEPTH-1].valid && ctrl_q[CTRL_DEPTH-1].eval;
    end
  end

  // stage 1: input beat; stage 2: scaled position
  logic signed [COORD_W-1:0] x1_q, y1_q;
  logic [TABLE_AW-1:0]       idx1_q, idx2_q, idx3_q;
  logic [PERM_W-1:0]         val1_q, val2_q, val3_q;
  logic signed [PROD_W-1:0]  px_q, py_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      x1_q   <= s_axis_tdata[47:16];
      y1_q   <= s_axis_tdata[79:48];
      idx1_q <= s_axis_tdata[7:0];
      val1_q <= s_axis_tdata[15:8];
      px_q   <= x1_q * $signed({1'b0, base_frequency_q});
      py_q   <= y1_q * $signed({1'b0, base_frequency_q});
      idx2_q <= idx1_q;
      val2_q <= val1_q;
      idx3_q <= idx2_q;
      val3_q <= val2_q;
    end
  end

  // table writes land in each copy as the write beat passes its read stage
  perm_wr_t wr_a, wr_b;

  always_comb begin
    if (clearing_q) begin
      wr_a = '{en: 1'b1, addr: clr_cnt_q, data: clr_cnt_q};
      wr_b = '{en: 1'b1, addr: clr_cnt_q, data: clr_cnt_q};
    end else begin
      wr_a = '{en: en && ctrl_q[1].valid && !ctrl_q[1].eval, addr: idx2_q, data: val2_q};
      wr_b = '{en: en && ctrl_q[2].valid && !ctrl_q[2].eval, addr: idx3_q, data: val3_q};
    end
  end

  logic signed [TW-1:0] terms [MAX_OCTAVES];

  for (genvar g = 0; g < MAX_OCTAVES; g++) begin : g_oct
    pfbm_octave #(
      .FRACTION_BITS (FRACTION_BITS),
      .OCT_IDX       (g)
    ) u_octave (
      .clk_i            (clk_i),
      .en_i             (en),
      .wr_a_i           (wr_a),
      .wr_b_i           (wr_b),
      .prod_x_i         (px_q),
      .prod_y_i         (py_q),
      .octave_count_i   (octave_count_q),
      .base_amplitude_i (base_amplitude_q),
      .term_o           (terms[g])
    );
  end

  logic signed [SW-1:0] sum;

  pfbm_sum #(
    .N  (MAX_OCTAVES),
    .IW (TW),
    .OW (SW)
  ) u_sum (
    .clk_i   (clk_i),
    .en_i    (en),
    .terms_i (terms),
    .sum_o   (sum)
  );

  // bring the sum to 16 fraction bits and saturate
  logic signed [QW-1:0] q_c;

  if (FRACTION_BITS >= 16) begin : g_down
    assign q_c = QW'(sum >>> (FRACTION_BITS - 16));
  end else begin : g_up
    assign q_c = QW'(sum) <<< (16 - FRACTION_BITS);
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      if (q_c > OUT_MAX) begin
        noise_q <= OUT_MAX[OUT_W-1:0];
      end else if (q_c < OUT_MIN) begin
        noise_q <= OUT_MIN[OUT_W-1:0];
      end else begin
        noise_q <= q_c[OUT_W-1:0];
      end
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {6'b0, noise_q};

  `PFBM_ASSERT(a_no_accept_in_clear, clearing_q |-> !s_axis_tready, "beat taken during table load")
  `PFBM_ASSERT_NEXT(a_clear_ends, clearing_q && (clr_cnt_q == TABLE_AW'(TABLE_ENTRIES_C - 1)), !clearing_q, "table load did not end")
  `PFBM_ASSERT_NEXT(a_result_out, en && ctrl_q[CTRL_DEPTH-1].valid && ctrl_q[CTRL_DEPTH-1].eval, out_vld_q, "evaluate beat lost")
  `PFBM_ASSERT_NEXT(a_write_no_out, en && ctrl_q[CTRL_DEPTH-1].valid && !ctrl_q[CTRL_DEPTH-1].eval, !out_vld_q, "write beat produced a result")

endmodule

// ===== tb/sv/tb_perlin_fbm_noise_2d.sv =====
// Self-checking testbench for the fractal gradient noise block
module tb_perlin_fbm_noise_2d;
  timeunit 1ns;
  timeprecision 1ps;
  import pfbm_pkg::*;

  typedef enum logic { CMD_WRITE = 1'b0, CMD_EVAL = 1'b1 } noise_cmd_e;
  typedef enum logic [1:0] {
    REG_OCTAVES = 2'd0, REG_FREQ = 2'd1, REG_AMP = 2'd2, REG_SPARE = 2'd3
  } noise_reg_e;

  typedef struct packed {
    noise_cmd_e         cmd;
    logic [31:0]        y;
    logic [31:0]        x;
    logic [PERM_W-1:0]  value;
    logic [TABLE_AW-1:0] index;
  } noise_beat_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [79:0] s_axis_tdata = '0;
  logic        s_axis_tuser = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i = '0;
  logic [23:0] cfg_data_i = '0;

  perlin_fbm_noise_2d dut (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // shadow state of the block
  logic [PERM_W-1:0] perm_shadow [TABLE_ENTRIES_C];
  logic [3:0]  octaves_q = 4'd4;
  logic [23:0] freq_q = 24'd83886;
  logic [15:0] amp_q = 16'd58982;

  noise_beat_t       beats_pending [$];
  noise_beat_t       beat_on_bus;
  logic [OUT_W-1:0]  noise_expected [$];
  int unsigned       send_idle_pct = 0;
  int unsigned       recv_idle_pct = 0;
  bit                failed = 1'b0;

  initial for (int i = 0; i < TABLE_ENTRIES_C; i++) perm_shadow[i] = i[7:0];

  function automatic longint fade_q(longint unsigned t);
    longint unsigned t2, t3, inner;
    t2 = (t * t) >> 16;
    t3 = (t2 * t) >> 16;
    inner = 6 * t2 + 10 * 64'd65536 - 15 * t;
    return longint'((t3 * inner) >> 16);
  endfunction

  function automatic longint lerp_q(longint f, longint a, longint b);
    return a + ((f * (b - a)) >>> 16);
  endfunction

  function automatic longint grad_dot(logic [7:0] h, longint dx, longint dy);
    case (h[1:0])
      2'd0: return dx + dy;
      2'd1: return -dx + dy;
      2'd2: return -dx - dy;
      default: return dx - dy;
    endcase
  endfunction

  function automatic longint cell_noise(longint unsigned px, longint unsigned py);
    logic [7:0] cx, cy, cx1, cy1, hbl, htl, hbr, htr;
    longint tx, ty, u, v;
    cx = px[47:40];
    cy = py[47:40];
    cx1 = cx + 8'd1;
    cy1 = cy + 8'd1;
    tx = longint'(px[39:24]);
    ty = longint'(py[39:24]);
    hbl = perm_shadow[8'(perm_shadow[cx] + cy)];
    htl = perm_shadow[8'(perm_shadow[cx] + cy1)];
    hbr = perm_shadow[8'(perm_shadow[cx1] + cy)];
    htr = perm_shadow[8'(perm_shadow[cx1] + cy1)];
    u = fade_q(tx);
    v = fade_q(ty);
    return lerp_q(u, lerp_q(v, grad_dot(hbl, tx, ty), grad_dot(htl, tx, ty - 65536)),
                  lerp_q(v, grad_dot(hbr, tx - 65536, ty),
                         grad_dot(htr, tx - 65536, ty - 65536)));
  endfunction

  function automatic logic [OUT_W-1:0] fbm_noise(logic [31:0] xc, logic [31:0] yc);
    longint x, y, sum, n;
    int cnt;
    longint unsigned px, py;
    x = longint'(signed'(xc));
    y = longint'(signed'(yc));
    sum = 0;
    cnt = (octaves_q > MAX_OCTAVES_C) ? MAX_OCTAVES_C : octaves_q;
    for (int i = 0; i < cnt; i++) begin
      px = unsigned'(x * longint'(freq_q)) << i;
      py = unsigned'(y * longint'(freq_q)) << i;
      n = cell_noise(px, py);
      sum += (n * longint'(amp_q)) >>> (16 + i);
    end
    if (sum > 131071) sum = 131071;
    if (sum < -131072) sum = -131072;
    return sum[OUT_W-1:0];
  endfunction

  // driver: one beat on the bus at a time, predicted when accepted
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else if (!s_axis_tvalid || s_axis_tready) begin
      if (s_axis_tvalid) begin
        if (beat_on_bus.cmd == CMD_WRITE) perm_shadow[beat_on_bus.index] = beat_on_bus.value;
        else noise_expected.push_back(fbm_noise(beat_on_bus.x, beat_on_bus.y));
      end
      if (beats_pending.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        beat_on_bus = beats_pending.pop_front();
        s_axis_tdata <= {beat_on_bus.y, beat_on_bus.x, beat_on_bus.value, beat_on_bus.index};
        s_axis_tuser <= beat_on_bus.cmd;
        s_axis_tvalid <= 1'b1;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // monitor: check each result beat, then pick the next ready level
  always @(posedge clk_i or negedge rst_ni) begin
    logic [OUT_W-1:0] want;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (noise_expected.size() == 0) begin
          $error("noise_value: unexpected beat, actual %0h", m_axis_tdata[OUT_W-1:0]);
          failed = 1'b1;
        end else begin
          want = noise_expected.pop_front();
          if (m_axis_tdata[OUT_W-1:0] !== want) begin
            $error("noise_value: expected %0h actual %0h", want, m_axis_tdata[OUT_W-1:0]);
            failed = 1'b1;
          end
        end
      end
      m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  task automatic write_reg(noise_reg_e idx, logic [23:0] data);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    case (idx)
      REG_OCTAVES: octaves_q = data[3:0];
      REG_FREQ:    freq_q = data;
      REG_AMP:     amp_q = data[15:0];
      default: ;
    endcase
  endtask

  task automatic drain();
    while (beats_pending.size() != 0 || s_axis_tvalid || noise_expected.size() != 0)
      @(posedge clk_i);
    // table writes leave no result, so let the pipeline empty
    repeat (30) @(posedge clk_i);
  endtask

  task automatic push_beat(noise_cmd_e c, logic [7:0] idx, logic [7:0] val,
                           logic [31:0] x, logic [31:0] y);
    noise_beat_t b;
    b.cmd = c; b.index = idx; b.value = val; b.x = x; b.y = y;
    beats_pending.push_back(b);
  endtask

  task automatic push_random(int n);
    logic [31:0] x, y;
    for (int k = 0; k < n; k++) begin
      if ($urandom_range(99) < 15) begin
        push_beat(CMD_WRITE, $urandom, $urandom, $urandom, $urandom);
      end else begin
        x = $urandom;
        y = $urandom;
        // half of the points near the origin, where low frequencies still vary
        if ($urandom_range(1)) begin
          x = 32'(signed'(x) >>> $urandom_range(20, 8));
          y = 32'(signed'(y) >>> $urandom_range(20, 8));
        end
        push_beat(CMD_EVAL, $urandom, $urandom, x, y);
      end
    end
  endtask

  initial begin
    logic [31:0] pts [6];
    pts = '{32'h0, 32'h7fff_ffff, 32'h8000_0000, 32'hffff_ffff, 32'h0001_0000, 32'h0000_ffff};
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: coordinate extremes at reset settings, table edges
    for (int i = 0; i < 6; i++) push_beat(CMD_EVAL, 8'hff, 8'hff, pts[i], pts[5 - i]);
    push_beat(CMD_EVAL, 8'h00, 8'h00, 32'h8000_0000, 32'h8000_0000);
    push_beat(CMD_EVAL, 8'h5a, 8'ha5, 32'h7fff_ffff, 32'h7fff_ffff);
    push_beat(CMD_WRITE, 8'h00, 8'hff, 32'hffff_ffff, 32'hffff_ffff);
    push_beat(CMD_WRITE, 8'hff, 8'h00, 32'h8000_0000, 32'h7fff_ffff);
    push_beat(CMD_WRITE, 8'h80, 8'h01, 32'h0, 32'h0);
    for (int i = 0; i < 6; i++) push_beat(CMD_EVAL, 8'h00, 8'h00, pts[i], pts[i]);
    push_beat(CMD_EVAL, 8'h00, 8'h00, 32'hff00_0000, 32'h00ff_8000);
    drain();

    for (int ph = 0; ph < 6; ph++) begin
      send_idle_pct = (ph < 2) ? 26 : (ph < 4) ? 47 : 0;
      recv_idle_pct = (ph < 2) ? 47 : (ph < 4) ? 26 : 0;
      case (ph)
        0: begin
          write_reg(REG_OCTAVES, 24'd8);
          write_reg(REG_FREQ, 24'd83886);
          write_reg(REG_AMP, 24'd58982);
        end
        1: begin
          write_reg(REG_OCTAVES, 24'd0);
          write_reg(REG_FREQ, 24'hff_ffff);
          write_reg(REG_AMP, 24'h00_ffff);
        end
        2: begin
          write_reg(REG_OCTAVES, 24'hff_ffff);
          write_reg(REG_AMP, 24'h00_ffff);
        end
        3: begin
          write_reg(REG_OCTAVES, 24'd1);
          write_reg(REG_FREQ, 24'd0);
          write_reg(REG_AMP, 24'd0);
          write_reg(REG_SPARE, 24'h55_aaaa);
        end
        4: begin
          write_reg(REG_OCTAVES, 24'd3);
          write_reg(REG_FREQ, 24'h10_0000);
          write_reg(REG_AMP, 24'h00_8000);
        end
        default: begin
          write_reg(REG_OCTAVES, $urandom_range(15));
          write_reg(REG_FREQ, $urandom);
          write_reg(REG_AMP, $urandom);
          write_reg(REG_SPARE, $urandom);
        end
      endcase
      push_random(315);
      drain();
    end

    if (!failed) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("Test completed with failures");
    $finish;
  end
endmodule
